@@ rtl/xps_pkg.sv @@
// Shared constants and types for the xorshift plus/star generator.
package xps_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned ROW_W  = 3;
  localparam int unsigned BANKS  = 2;
  localparam int unsigned ROWS   = 8;

  localparam int unsigned SH_A_SHORT = 23;
  localparam int unsigned SH_B_SHORT = 18;
  localparam int unsigned SH_C_SHORT = 5;
  localparam int unsigned SH_A_LONG  = 31;
  localparam int unsigned SH_B_LONG  = 11;
  localparam int unsigned SH_C_LONG  = 30;

  localparam logic KIND_NEXT = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic CFG_USE_LONG  = 1'b0;
  localparam logic CFG_STAR_MULT = 1'b1;

  localparam logic [WORD_W-1:0] STAR_MULT_RESET = 64'd1181783497276652981;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic             kind;
    logic             long_mode;
    logic             cur_odd;
    logic [ROW_W-1:0] wrow;
    logic [IDX_W-1:0] seed_index;
    word_t            seed_word;
  } s1_t;

endpackage

@@ rtl/xorshift_plus_star_generator.sv @@
// Top level: banked state memory, xorshift update, output multiplier.
// Generator of 64-bit pseudo-random words, xorshift128+ (use_long_state = 0) or
// xorshift1024* (use_long_state = 1). The block takes one item per cycle, loads
// and next requests alike, while out_ready does not hold the pipeline, and a
// next item's word passes through the stage 1, 2 and 3 registers into the output
// register. The sixteen state words live in two 8 x 64 memories, even entries in
// one and odd entries in the other, so that the two words of each step come from
// different banks; each bank does one read and one write per cycle, with the
// write of the step in flight forwarded to the read of the next item. Per-entry
// valid bits make reset take effect at once: no clearing pass. The output
// multiply is split into 32 x 32 partial products over two stages.
module xorshift_plus_star_generator
  import xps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [IDX_W-1:0]  in_seed_index,
  input  logic [WORD_W-1:0] in_seed_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_random_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  logic             use_long_r;
  word_t            star_mult_r;
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] ptr_inc;

  logic             s1_v_r;
  s1_t              s1_r;
  word_t            rd_data_r [BANKS];

  logic             s2_v_r;
  logic             s2_star_r;
  word_t            s2_fresh_r;
  word_t            s2_sum_r;

  logic             s3_v_r;
  logic             s3_star_r;
  word_t            s3_pp_r;
  logic [HALF_W-1:0] s3_cross_r;
  word_t            s3_sum_r;

  logic             out_valid_r;
  word_t            out_word_r;

  logic en1, en2, en3, in_acc;

  logic             bank_we [BANKS];
  logic [ROW_W-1:0] bank_wa [BANKS];
  word_t            bank_wd [BANKS];
  logic [ROW_W-1:0] bank_ra [BANKS];

  word_t cur_w, prev_w, mix_w, fresh_w, sum_w;
  word_t prod_ll;
  logic [HALF_W-1:0] prod_lh, prod_hl;

  assign en3       = !out_valid_r || out_ready;
  assign en2       = !s3_v_r || en3;
  assign en1       = !s1_v_r || en2;
  assign in_ready  = en1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_random_word = out_word_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_long_r  <= 1'b0;
      star_mult_r <= STAR_MULT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_USE_LONG:  use_long_r  <= cfg_data[0];
        CFG_STAR_MULT: star_mult_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ring pointer advances when a long-mode next item is accepted
  assign ptr_inc = ptr_r + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (in_acc && in_kind == KIND_NEXT && use_long_r) begin
      ptr_r <= ptr_inc;
    end
  end

  // read rows: even bank holds entries 0,2,..; odd bank 1,3,..
  always_comb begin
    bank_ra[0] = '0;
    bank_ra[1] = '0;
    if (use_long_r) begin
      if (ptr_r[0]) begin
        bank_ra[1] = ptr_r[IDX_W-1:1];
        bank_ra[0] = ptr_inc[IDX_W-1:1];
      end else begin
        bank_ra[0] = ptr_r[IDX_W-1:1];
        bank_ra[1] = ptr_inc[IDX_W-1:1];
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.kind       <= in_kind;
      s1_r.long_mode  <= use_long_r;
      s1_r.cur_odd    <= ptr_inc[0];
      s1_r.wrow       <= ptr_inc[IDX_W-1:1];
      s1_r.seed_index <= in_seed_index;
      s1_r.seed_word  <= in_seed_word;
    end
  end

  // state banks with valid bits and write-to-read forwarding
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    word_t           mem [ROWS];
    logic [ROWS-1:0] vld_r;

    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        mem[bank_wa[b]] <= bank_wd[b];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= '0;
      end else if (bank_we[b]) begin
        vld_r[bank_wa[b]] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (in_acc) begin
        if (bank_we[b] && bank_wa[b] == bank_ra[b]) begin
          rd_data_r[b] <= bank_wd[b];
        end else if (vld_r[bank_ra[b]]) begin
          rd_data_r[b] <= mem[bank_ra[b]];
        end else begin
          rd_data_r[b] <= '0;
        end
      end
    end
  end

  // stage 1 datapath: state update and write-back
  always_comb begin
    cur_w   = '0;
    prev_w  = '0;
    mix_w   = '0;
    fresh_w = '0;
    if (s1_r.long_mode) begin
      cur_w   = s1_r.cur_odd ? rd_data_r[1] : rd_data_r[0];
      prev_w  = s1_r.cur_odd ? rd_data_r[0] : rd_data_r[1];
      mix_w   = cur_w ^ (cur_w << SH_A_LONG);
      fresh_w = mix_w ^ prev_w ^ (mix_w >> SH_B_LONG) ^ (prev_w >> SH_C_LONG);
    end else begin
      cur_w   = rd_data_r[0];
      prev_w  = rd_data_r[1];
      mix_w   = cur_w ^ (cur_w << SH_A_SHORT);
      fresh_w = mix_w ^ prev_w ^ (mix_w >> SH_B_SHORT) ^ (prev_w >> SH_C_SHORT);
    end
    sum_w = fresh_w + prev_w;
  end

  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      bank_we[b] = 1'b0;
      bank_wa[b] = '0;
      bank_wd[b] = fresh_w;
    end
    if (s1_v_r && en2) begin
      if (s1_r.kind == KIND_LOAD) begin
        bank_we[s1_r.seed_index[0]] = 1'b1;
        bank_wa[s1_r.seed_index[0]] = s1_r.seed_index[IDX_W-1:1];
        bank_wd[s1_r.seed_index[0]] = s1_r.seed_word;
      end else if (s1_r.long_mode) begin
        bank_we[s1_r.cur_odd] = 1'b1;
        bank_wa[s1_r.cur_odd] = s1_r.wrow;
      end else begin
        bank_we[0] = 1'b1;
        bank_wd[0] = prev_w;
        bank_we[1] = 1'b1;
      end
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r && s1_r.kind == KIND_NEXT;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_star_r  <= s1_r.long_mode;
      s2_fresh_r <= fresh_w;
      s2_sum_r   <= sum_w;
    end
  end

  // stage 3: partial products, low 64 bits only
  assign prod_ll = WORD_W'(s2_fresh_r[HALF_W-1:0]) * WORD_W'(star_mult_r[HALF_W-1:0]);
  assign prod_lh = s2_fresh_r[HALF_W-1:0] * star_mult_r[WORD_W-1:HALF_W];
  assign prod_hl = s2_fresh_r[WORD_W-1:HALF_W] * star_mult_r[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en2) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s3_star_r  <= s2_star_r;
      s3_pp_r    <= prod_ll;
      s3_cross_r <= prod_lh + prod_hl;
      s3_sum_r   <= s2_sum_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_word_r <= s3_star_r ? (s3_pp_r + {s3_cross_r, {HALF_W{1'b0}}}) : s3_sum_r;
    end
  end

  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_kind == KIND_NEXT && use_long_r) |=> $stable(ptr_r))
    else $error("ring pointer moved without a long-mode next item");

  a_long_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && en2 && s1_r.kind == KIND_NEXT && s1_r.long_mode)
      |-> $onehot({bank_we[1], bank_we[0]}))
    else $error("long-mode step must write exactly one bank");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && en2 && s1_r.kind == KIND_LOAD) |=> !s2_v_r)
    else $error("load item advanced into the result path");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !en2) |=> (s1_v_r && $stable(s1_r)))
    else $error("stage 1 lost its item while stalled");

endmodule

@@ tb/xorshift_plus_star_generator_tb.sv @@
// Self-checking testbench for the xorshift128+ / xorshift1024* word generator.
module xorshift_plus_star_generator_tb
  import xps_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_kind = KIND_NEXT;
  logic [IDX_W-1:0]  in_seed_index = '0;
  word_t             in_seed_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  word_t             out_random_word;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_USE_LONG;
  word_t             cfg_data = '0;

  xorshift_plus_star_generator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_seed_index   (in_seed_index),
    .in_seed_word    (in_seed_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #6 clk = ~clk;

  // generator state mirror
  word_t            seed_bank [16];
  logic [IDX_W-1:0] ring_pos;
  logic             long_mode_cfg;
  word_t            star_mult_cfg;
  word_t            expected_words [$];

  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit sender_bursty = 1'b1;
  int hold_request = 0;
  int hold_left = 0;
  int rx_run_left = 0;
  bit rx_ready_run = 1'b1;

  function automatic word_t advance_plus128();
    word_t a, b, fresh;
    a = seed_bank[0];
    b = seed_bank[1];
    seed_bank[0] = b;
    a = a ^ (a << SH_A_SHORT);
    fresh = a ^ b ^ (a >> SH_B_SHORT) ^ (b >> SH_C_SHORT);
    seed_bank[1] = fresh;
    return fresh + b;
  endfunction

  function automatic word_t advance_star1024();
    word_t prev, cur, fresh, prod;
    prev = seed_bank[ring_pos];
    ring_pos = ring_pos + IDX_W'(1);
    cur = seed_bank[ring_pos];
    cur = cur ^ (cur << SH_A_LONG);
    fresh = cur ^ prev ^ (cur >> SH_B_LONG) ^ (prev >> SH_C_LONG);
    seed_bank[ring_pos] = fresh;
    prod = fresh * star_mult_cfg;
    return prod;
  endfunction

  function automatic word_t rand_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return word_t'(1) << $urandom_range(0, WORD_W - 1);
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("[%0t] ERROR %s: got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected random_word", out_random_word, '0);
      end else begin
        want = expected_words.pop_front();
        if (out_random_word !== want) begin
          report_mismatch("random_word", out_random_word, want);
        end
      end
    end
  end

  // receiver: long hold-offs on request, otherwise random runs of ready and stall
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_run_left == 0) begin
        rx_ready_run = ($urandom_range(0, 2) != 0);
        rx_run_left = rx_ready_run ? $urandom_range(1, 40) : $urandom_range(1, 6);
      end
      rx_run_left--;
      out_ready <= rx_ready_run;
    end
  end

  task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx, input word_t word);
    int gap;
    gap = 0;
    if (sender_bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 7);
      end
      burst_left--;
    end
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_seed_index <= idx;
    in_seed_word <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KIND_LOAD) begin
      seed_bank[idx] = word;
    end else if (long_mode_cfg) begin
      expected_words.push_back(advance_star1024());
    end else begin
      expected_words.push_back(advance_plus128());
    end
  endtask

  task automatic send_next();
    send_item(KIND_NEXT, 4'($urandom), rand_word());
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input word_t data);
    settle_block();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_USE_LONG) long_mode_cfg = data[0];
    else star_mult_cfg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 22) send_item(KIND_LOAD, 4'($urandom), rand_word());
      else send_next();
    end
  endtask

  task automatic test_zero_state();
    send_item(KIND_NEXT, 4'hf, '1);
    send_item(KIND_NEXT, 4'h0, '0);
  endtask

  task automatic test_plus_mode();
    send_item(KIND_LOAD, 4'd0, '1);
    send_item(KIND_LOAD, 4'd1, 64'd1);
    send_item(KIND_LOAD, 4'd15, 64'haaaa_aaaa_aaaa_aaaa);
    repeat (3) send_next();
  endtask

  task automatic test_star_mode();
    write_register(CFG_USE_LONG, 64'd1);
    send_item(KIND_LOAD, 4'd3, 64'h8000_0000_0000_0000);
    send_item(KIND_LOAD, 4'd4, 64'h5555_5555_5555_5555);
    repeat (4) send_next();
  endtask

  task automatic test_multiplier_extremes();
    write_register(CFG_STAR_MULT, '0);
    repeat (2) send_next();
    write_register(CFG_STAR_MULT, '1);
    repeat (2) send_next();
    write_register(CFG_STAR_MULT, 64'd1);
    send_next();
  endtask

  task automatic test_mode_carryover();
    write_register(CFG_USE_LONG, 64'd0);
    repeat (2) send_next();
  endtask

  task automatic test_backpressure();
    write_register(CFG_USE_LONG, 64'd1);
    write_register(CFG_STAR_MULT, rand_word());
    @(posedge clk);
    hold_request = 300;
    sender_bursty = 1'b0;
    for (int i = 0; i < 80; i++) begin
      if (i % 9 == 4) send_item(KIND_LOAD, 4'($urandom), rand_word());
      else send_next();
    end
    sender_bursty = 1'b1;
    settle_block();
  endtask

  task automatic test_random_streams();
    write_register(CFG_USE_LONG, 64'd0);
    send_random_items(400);
    write_register(CFG_USE_LONG, 64'd1);
    write_register(CFG_STAR_MULT, {$urandom, $urandom});
    send_random_items(400);
    write_register(CFG_STAR_MULT, '1);
    send_random_items(150);
    write_register(CFG_USE_LONG, 64'd0);
    sender_bursty = 1'b0;
    send_random_items(150);
    sender_bursty = 1'b1;
    send_random_items(150);
    write_register(CFG_USE_LONG, 64'd1);
    write_register(CFG_STAR_MULT, STAR_MULT_RESET);
    send_random_items(300);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) seed_bank[i] = '0;
    ring_pos = '0;
    long_mode_cfg = 1'b0;
    star_mult_cfg = STAR_MULT_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_state();
    test_plus_mode();
    test_star_mode();
    test_multiplier_extremes();
    test_mode_carryover();
    test_backpressure();
    test_random_streams();

    settle_block();
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
